// ===== hdl/tpg_pkg.sv =====
package tpg_pkg;

    localparam int TRAIL_POINTS_DEF = 64;
    localparam int START_RED_DEF    = 230;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam logic [17:0] RST_COS_YAW   = 18'd46341;
    localparam logic [17:0] RST_SIN_YAW   = 18'd46341;
    localparam logic [17:0] RST_COS_PITCH = 18'd65536;
    localparam logic [17:0] RST_SIN_PITCH = 18'd0;
    localparam logic [15:0] RST_FOCAL     = 16'd15360;
    localparam logic [15:0] RST_CENTER_X  = 16'd0;
    localparam logic [15:0] RST_CENTER_Y  = 16'd0;
    localparam logic [15:0] RST_TIME_STEP = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_YAW     = 3'd0,
        CFG_SIN_YAW     = 3'd1,
        CFG_COS_PITCH   = 3'd2,
        CFG_SIN_PITCH   = 3'd3,
        CFG_FOCAL_SCALE = 3'd4,
        CFG_CENTER_X    = 3'd5,
        CFG_CENTER_Y    = 3'd6,
        CFG_TIME_STEP   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [17:0] cos_yaw;
        logic signed [17:0] sin_yaw;
        logic signed [17:0] cos_pitch;
        logic signed [17:0] sin_pitch;
        logic [15:0]        focal_scale;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        time_step;
    } cfg_t;

    // Three lanes x, y, z of 32-bit signed Q16.16 values.
    typedef logic [2:0][31:0] vec_t;

    // One body as it waits in the queue; acceleration is already scaled by dt.
    typedef struct packed {
        vec_t pos;
        vec_t vel;
        vec_t acc_dt;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] red;
        vec_t       pos;
    } point_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] red;
    } meta_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // x * dt with dt unsigned Q0.16, floored back to Q16.16.
    function automatic logic signed [31:0] scale_dt(input logic signed [31:0] x,
                                                    input logic [15:0] dt);
        logic signed [48:0] prod;
        prod = x * $signed({1'b0, dt});
        return prod[47:16];
    endfunction

    // Drops 24 fraction bits toward zero and clamps to a 16-bit pixel.
    function automatic logic signed [15:0] trunc_sat16(input logic signed [55:0] v);
        logic signed [55:0] biased;
        logic signed [31:0] q;
        logic signed [15:0] r;
        biased = v[55] ? (v + 56'sd16777215) : v;
        q = biased[55:24];
        if (q > 32'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (q < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/tpg_front.sv =====
module tpg_front
    import tpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    input  logic [31:0] acc_x,
    input  logic [31:0] acc_y,
    input  logic [31:0] acc_z,
    input  logic [15:0] time_step,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_wdata
);

    logic f_valid_reg;
    logic f_valid_next;
    vec_t f_pos_reg;
    vec_t f_vel_reg;
    vec_t f_acc_reg;
    logic accept;

    assign in_stall = f_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = f_valid_reg && !q_full;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_pos_reg <= {pos_z, pos_y, pos_x};
            f_vel_reg <= {vel_z, vel_y, vel_x};
            f_acc_reg <= {acc_z, acc_y, acc_x};
        end
    end

    // The acceleration term is the same for every step of a trail, so it is
    // scaled once here and the queue entry registers the product.
    always_comb
    begin
        q_wdata.pos = f_pos_reg;
        q_wdata.vel = f_vel_reg;
        for (int k = 0; k < 3; k++)
        begin
            q_wdata.acc_dt[k] = scale_dt($signed(f_acc_reg[k]), time_step);
        end
    end

endmodule

// ===== hdl/tpg_queue.sv =====
module tpg_queue
    import tpg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     wdata,
    input  logic      pop,
    output item_t     rdata,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/tpg_stepper.sv =====
module tpg_stepper
    import tpg_pkg::*;
#(
    parameter int TRAIL_POINTS = TRAIL_POINTS_DEF,
    parameter int START_RED    = START_RED_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic [15:0] time_step,
    input  item_t       q_rdata,
    input  logic        q_empty,
    output logic        q_pop,
    output point_t      pt
);

    localparam int CNT_W = (TRAIL_POINTS > 1) ? $clog2(TRAIL_POINTS) : 1;

    // Velocity stage: one step of v per cycle while the back end advances.
    logic             a_valid_reg;
    logic             a_valid_next;
    logic             a_first_reg;
    logic             a_last_reg;
    logic [7:0]       a_red_reg;
    logic [1:0]       a_mod_reg;
    logic [CNT_W-1:0] a_cnt_reg;
    vec_t             a_v_reg;
    vec_t             a_p0_reg;
    vec_t             ad_reg;

    // Position stage: steps p from the velocity stage's registered v of the same step.
    logic             b_valid_reg;
    logic             b_last_reg;
    logic [7:0]       b_red_reg;
    vec_t             b_p_reg;

    logic             cont;
    logic             start;
    vec_t             v_step;
    vec_t             v_load;
    vec_t             p_step;
    logic [7:0]       red_step;
    logic [1:0]       mod_step;

    assign cont  = a_valid_reg && !a_last_reg;
    assign start = !cont && !q_empty;
    assign q_pop = adv && start;

    always_comb
    begin
        logic signed [31:0] dv;
        logic [31:0]        base;
        for (int k = 0; k < 3; k++)
        begin
            v_step[k] = sat32({a_v_reg[k][31], a_v_reg[k]} - {ad_reg[k][31], ad_reg[k]});
            v_load[k] = sat32({q_rdata.vel[k][31], q_rdata.vel[k]}
                              - {q_rdata.acc_dt[k][31], q_rdata.acc_dt[k]});
            dv        = scale_dt($signed(a_v_reg[k]), time_step);
            base      = a_first_reg ? a_p0_reg[k] : b_p_reg[k];
            p_step[k] = sat32({base[31], base} - {dv[31], dv});
        end
        // Red drops after every third point, starting with the first.
        red_step = ((a_red_reg != 8'd0) && (a_mod_reg == 2'd0)) ? a_red_reg - 8'd1 : a_red_reg;
        mod_step = (a_mod_reg == 2'd2) ? 2'd0 : a_mod_reg + 2'd1;
        a_valid_next = cont || start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cont)
            begin
                a_v_reg     <= v_step;
                a_first_reg <= 1'b0;
                a_last_reg  <= (a_cnt_reg == CNT_W'(TRAIL_POINTS - 2));
                a_cnt_reg   <= a_cnt_reg + 1'b1;
                a_red_reg   <= red_step;
                a_mod_reg   <= mod_step;
            end
            else if (start)
            begin
                a_v_reg     <= v_load;
                ad_reg      <= q_rdata.acc_dt;
                a_p0_reg    <= q_rdata.pos;
                a_first_reg <= 1'b1;
                a_last_reg  <= (TRAIL_POINTS == 1);
                a_cnt_reg   <= '0;
                a_red_reg   <= 8'(START_RED);
                a_mod_reg   <= 2'd0;
            end
            if (a_valid_reg)
            begin
                b_p_reg    <= p_step;
                b_last_reg <= a_last_reg;
                b_red_reg  <= a_red_reg;
            end
        end
    end

    assign pt.valid = b_valid_reg;
    assign pt.last  = b_last_reg;
    assign pt.red   = b_red_reg;
    assign pt.pos   = b_p_reg;

endmodule

// ===== hdl/tpg_project.sv =====
module tpg_project
    import tpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cfg_t        cfg,
    input  point_t      pt,
    output logic        out_valid,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [7:0]  red_level,
    output logic        last_point
);

    localparam int STAGES = 6;

    meta_t              meta_reg [STAGES];

    logic signed [49:0] c_xc_reg;
    logic signed [49:0] c_zs_reg;
    logic signed [49:0] c_yc_reg;
    logic signed [50:0] d_px_reg;
    logic signed [34:0] d_pzf_reg;
    logic signed [49:0] d_yc_reg;
    logic signed [50:0] e_px_reg;
    logic signed [52:0] e_mps_reg;
    logic signed [49:0] e_yc_reg;
    logic signed [34:0] f_pxf_reg;
    logic signed [37:0] f_pyf_reg;
    logic signed [51:0] g_sx_reg;
    logic signed [54:0] g_sy_reg;
    logic signed [55:0] h_sx_reg;
    logic signed [55:0] h_sy_reg;

    logic               out_valid_reg;
    logic [15:0]        pixel_x_reg;
    logic [15:0]        pixel_y_reg;
    logic [7:0]         red_level_reg;
    logic               last_point_reg;

    logic signed [50:0] pz;
    logic signed [53:0] py;
    logic signed [39:0] cx_shift;
    logic signed [39:0] cy_shift;

    always_comb
    begin
        pz       = 51'(c_zs_reg) - 51'(c_xc_reg);
        py       = 54'(e_yc_reg) - 54'(e_mps_reg);
        cx_shift = {cfg.center_x, 24'd0};
        cy_shift = {cfg.center_y, 24'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                meta_reg[s] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            meta_reg[0] <= '{valid: pt.valid, last: pt.last, red: pt.red};
            for (int s = 1; s < STAGES; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
            out_valid_reg <= meta_reg[STAGES-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Rotation products at 32 fraction bits.
            c_xc_reg  <= $signed(pt.pos[0]) * cfg.cos_yaw;
            c_zs_reg  <= $signed(pt.pos[2]) * cfg.sin_yaw;
            c_yc_reg  <= $signed(pt.pos[1]) * cfg.cos_pitch;

            d_px_reg  <= 51'(c_xc_reg) + 51'(c_zs_reg);
            d_pzf_reg <= pz[50:16];
            d_yc_reg  <= c_yc_reg;

            e_px_reg  <= d_px_reg;
            e_mps_reg <= d_pzf_reg * cfg.sin_pitch;
            e_yc_reg  <= d_yc_reg;

            f_pxf_reg <= e_px_reg[50:16];
            f_pyf_reg <= py[53:16];

            g_sx_reg  <= f_pxf_reg * $signed({1'b0, cfg.focal_scale});
            g_sy_reg  <= f_pyf_reg * $signed({1'b0, cfg.focal_scale});

            h_sx_reg  <= 56'(g_sx_reg) + 56'(cx_shift);
            h_sy_reg  <= 56'(g_sy_reg) + 56'(cy_shift);

            pixel_x_reg    <= trunc_sat16(h_sx_reg);
            pixel_y_reg    <= trunc_sat16(h_sy_reg);
            red_level_reg  <= meta_reg[STAGES-1].red;
            last_point_reg <= meta_reg[STAGES-1].last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign red_level  = red_level_reg;
    assign last_point = last_point_reg;

endmodule

// ===== hdl/trail_point_generator.sv =====
// Trail point generator: each accepted item is one body (position, velocity and
// acceleration in signed Q16.16) and yields TRAIL_POINTS result items, one per
// cycle while the output is not stalled, each a screen pixel of a backward-Euler
// step with its red level; the final one has last_point set. The step recurrence
// closes through one register each in the velocity and position stages, and
// the next queued body enters the velocity stage as the previous one's last
// step leaves it. A front register scales the acceleration by dt and hands
// bodies to a QUEUE_DEPTH-entry queue, so input is taken while a trail is being
// produced. An item passes the front register, the queue, the velocity, position
// and projection stages and the output register. Configuration is a plain
// indexed write and should only change while no trail is pending.
module trail_point_generator
    import tpg_pkg::*;
#(
    parameter int TRAIL_POINTS = TRAIL_POINTS_DEF,
    parameter int START_RED    = START_RED_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           pos_x,
    input  logic [31:0]           pos_y,
    input  logic [31:0]           pos_z,
    input  logic [31:0]           vel_x,
    input  logic [31:0]           vel_y,
    input  logic [31:0]           vel_z,
    input  logic [31:0]           acc_x,
    input  logic [31:0]           acc_y,
    input  logic [31:0]           acc_z,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           pixel_x,
    output logic [15:0]           pixel_y,
    output logic [7:0]            red_level,
    output logic                  last_point,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      q_push;
    logic      q_pop;
    item_t     q_wdata;
    item_t     q_rdata;
    q_status_t q_status;
    point_t    pt;
    logic      adv;

    // The whole back end moves together whenever the output register can load.
    assign adv = !out_valid || !out_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_COS_YAW:     cfg_next.cos_yaw     = cfg_data;
                CFG_SIN_YAW:     cfg_next.sin_yaw     = cfg_data;
                CFG_COS_PITCH:   cfg_next.cos_pitch   = cfg_data;
                CFG_SIN_PITCH:   cfg_next.sin_pitch   = cfg_data;
                CFG_FOCAL_SCALE: cfg_next.focal_scale = cfg_data[15:0];
                CFG_CENTER_X:    cfg_next.center_x    = cfg_data[15:0];
                CFG_CENTER_Y:    cfg_next.center_y    = cfg_data[15:0];
                CFG_TIME_STEP:   cfg_next.time_step   = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_yaw     <= RST_COS_YAW;
            cfg_reg.sin_yaw     <= RST_SIN_YAW;
            cfg_reg.cos_pitch   <= RST_COS_PITCH;
            cfg_reg.sin_pitch   <= RST_SIN_PITCH;
            cfg_reg.focal_scale <= RST_FOCAL;
            cfg_reg.center_x    <= RST_CENTER_X;
            cfg_reg.center_y    <= RST_CENTER_Y;
            cfg_reg.time_step   <= RST_TIME_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .time_step (cfg_reg.time_step),
        .q_full    (q_status.full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    tpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    tpg_stepper #(
        .TRAIL_POINTS (TRAIL_POINTS),
        .START_RED    (START_RED)
    ) u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .time_step (cfg_reg.time_step),
        .q_rdata   (q_rdata),
        .q_empty   (q_status.empty),
        .q_pop     (q_pop),
        .pt        (pt)
    );

    tpg_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .pt         (pt),
        .out_valid  (out_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red_level  (red_level),
        .last_point (last_point)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_status.full)
        else $error("input stalled while the queue has room");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tpg_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TRAIL          = TRAIL_POINTS_DEF;
    localparam int RANDOM_BODIES  = 34;
    localparam int PHASES         = 7;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_AFTER     = 22 * TRAIL;
    localparam int HOLD_CYCLES    = 800;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [31:0] Q_ZERO = 32'h0000_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_NEG  = 32'hFFFF_FFFF;
    localparam logic [31:0] Q_ALT1 = 32'hAAAA_AAAA;
    localparam logic [31:0] Q_ALT0 = 32'h5555_5555;

    localparam longint S32_MAX = 64'sh7FFF_FFFF;
    localparam longint S32_MIN = -64'sh8000_0000;
    localparam longint PIX_MAX = 32767;
    localparam longint PIX_MIN = -32768;

    localparam logic [17:0] NEG_UNIT = 18'h30000;

    typedef enum logic [1:0] {
        SENDER_SLOW,
        RECEIVER_SLOW,
        NO_IDLE
    } pace_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] acc_x;
        logic [31:0] acc_y;
        logic [31:0] acc_z;
    } body_t;

    typedef struct packed {
        logic        pinned;
        logic [15:0] px;
        logic [15:0] py;
    } pixel_pin_t;

    typedef struct packed {
        body_t      body;
        pixel_pin_t pin;
    } body_row_t;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  red;
        logic        last;
    } trail_pixel_t;

    typedef struct packed {
        logic [17:0] cos_yaw;
        logic [17:0] sin_yaw;
        logic [17:0] cos_pitch;
        logic [17:0] sin_pitch;
        logic [17:0] focal;
        logic [17:0] center_x;
        logic [17:0] center_y;
        logic [17:0] time_step;
    } view_set_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [31:0]           pos_x      = '0;
    logic [31:0]           pos_y      = '0;
    logic [31:0]           pos_z      = '0;
    logic [31:0]           vel_x      = '0;
    logic [31:0]           vel_y      = '0;
    logic [31:0]           vel_z      = '0;
    logic [31:0]           acc_x      = '0;
    logic [31:0]           acc_y      = '0;
    logic [31:0]           acc_z      = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [15:0]           pixel_x;
    logic [15:0]           pixel_y;
    logic [7:0]            red_level;
    logic                  last_point;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    pace_t        pace = SENDER_SLOW;
    int           bodies_sent  = 0;
    int           pixels_seen  = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    trail_pixel_t pending_pixels [$];
    pixel_pin_t   pin_queue [$];
    logic [17:0]  view_regs [8];

    // Rows that carry a pinned pixel hold it on every point of the trail, since
    // the body never moves; they assume the view registers as they come out of reset.
    body_row_t directed_rows [16] = '{
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b1, 16'h0000, 16'h0000}},
        '{'{Q_MAX, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b1, 16'h7FFF, 16'h0000}},
        '{'{Q_MIN, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b1, 16'h8000, 16'h0000}},
        '{'{Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b1, 16'h0000, 16'h7FFF}},
        '{'{Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b1, 16'h0000, 16'h8000}},
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, Q_MAX, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_MIN, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{32'h0064_0000, 32'hFFCE_0000, 32'h0014_0000, 32'h0003_0000, 32'h0001_0000,
            32'hFFFE_0000, 32'h0000_4000, 32'hFFFF_8000, 32'h0009_CCCD},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG, Q_NEG},
          '{1'b0, 16'h0000, 16'h0000}},
        '{'{32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_0001, 32'h0000_0001, Q_NEG,
            32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000, 32'h0009_CCCD},
          '{1'b0, 16'h0000, 16'h0000}}
    };

    trail_point_generator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .acc_x      (acc_x),
        .acc_y      (acc_y),
        .acc_z      (acc_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red_level  (red_level),
        .last_point (last_point),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        view_regs[CFG_COS_YAW]     = RST_COS_YAW;
        view_regs[CFG_SIN_YAW]     = RST_SIN_YAW;
        view_regs[CFG_COS_PITCH]   = RST_COS_PITCH;
        view_regs[CFG_SIN_PITCH]   = RST_SIN_PITCH;
        view_regs[CFG_FOCAL_SCALE] = {2'b00, RST_FOCAL};
        view_regs[CFG_CENTER_X]    = {2'b00, RST_CENTER_X};
        view_regs[CFG_CENTER_Y]    = {2'b00, RST_CENTER_Y};
        view_regs[CFG_TIME_STEP]   = {2'b00, RST_TIME_STEP};
    end

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint toward_zero24(input longint x);
        return (x < 0) ? -((-x) >>> 24) : (x >>> 24);
    endfunction

    // Walks the body backward in time and queues one projected pixel per step.
    task automatic project_trail(input body_t b, input pixel_pin_t pin);
        longint       p [3];
        longint       v [3];
        longint       a [3];
        longint       cyw, syw, cpt, spt, f, dt, cx, cy;
        longint       px, pz, py, sx, sy;
        logic [7:0]   red;
        trail_pixel_t pt;
        cyw = longint'($signed(view_regs[CFG_COS_YAW]));
        syw = longint'($signed(view_regs[CFG_SIN_YAW]));
        cpt = longint'($signed(view_regs[CFG_COS_PITCH]));
        spt = longint'($signed(view_regs[CFG_SIN_PITCH]));
        f   = longint'(view_regs[CFG_FOCAL_SCALE][15:0]);
        dt  = longint'(view_regs[CFG_TIME_STEP][15:0]);
        cx  = longint'($signed(view_regs[CFG_CENTER_X][15:0]));
        cy  = longint'($signed(view_regs[CFG_CENTER_Y][15:0]));
        p[0] = longint'($signed(b.pos_x));
        p[1] = longint'($signed(b.pos_y));
        p[2] = longint'($signed(b.pos_z));
        v[0] = longint'($signed(b.vel_x));
        v[1] = longint'($signed(b.vel_y));
        v[2] = longint'($signed(b.vel_z));
        a[0] = longint'($signed(b.acc_x));
        a[1] = longint'($signed(b.acc_y));
        a[2] = longint'($signed(b.acc_z));
        red = 8'(START_RED_DEF);
        for (int i = 0; i < TRAIL; i++)
        begin
            for (int k = 0; k < 3; k++)
                v[k] = clamp(v[k] - ((a[k] * dt) >>> 16), S32_MIN, S32_MAX);
            for (int k = 0; k < 3; k++)
                p[k] = clamp(p[k] - ((v[k] * dt) >>> 16), S32_MIN, S32_MAX);
            px = p[0] * cyw + p[2] * syw;
            pz = -p[0] * cyw + p[2] * syw;
            py = p[1] * cpt - (pz >>> 16) * spt;
            sx = (px >>> 16) * f + (cx <<< 24);
            sy = (py >>> 16) * f + (cy <<< 24);
            sx = clamp(toward_zero24(sx), PIX_MIN, PIX_MAX);
            sy = clamp(toward_zero24(sy), PIX_MIN, PIX_MAX);
            pt.px   = pin.pinned ? pin.px : sx[15:0];
            pt.py   = pin.pinned ? pin.py : sy[15:0];
            pt.red  = red;
            pt.last = (i == TRAIL - 1);
            pending_pixels.push_back(pt);
            // The red level fades by one on every third point until it bottoms out.
            if (red != 8'd0 && (i % 3) == 0)
                red = red - 8'd1;
        end
    endtask

    task automatic note_mismatch(input string what, input trail_pixel_t want);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected x=%0d y=%0d red=%0d last=%0b, got x=%0d y=%0d red=%0d last=%0b",
                     $time, what, $signed(want.px), $signed(want.py), want.red, want.last,
                     $signed(pixel_x), $signed(pixel_y), red_level, last_point);
        end
    endtask

    always @(posedge clk)
    begin
        body_t        seen;
        pixel_pin_t   pin;
        trail_pixel_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            seen = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z};
            pin = '0;
            if (pin_queue.size() != 0)
                pin = pin_queue.pop_front();
            project_trail(seen, pin);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
            begin
                note_mismatch("pixel with nothing pending", '0);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.px || pixel_y !== want.py ||
                    red_level !== want.red || last_point !== want.last)
                    note_mismatch("pixel mismatch", want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit sender_pause();
        case (pace)
            SENDER_SLOW:   return $urandom_range(0, 99) < 36;
            RECEIVER_SLOW: return $urandom_range(0, 99) < 45;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pause();
        case (pace)
            SENDER_SLOW:   return $urandom_range(0, 99) < 45;
            RECEIVER_SLOW: return $urandom_range(0, 99) < 36;
            default:       return 1'b0;
        endcase
    endfunction

    // The output side stalls at random outside the no-idle pace, and once holds off
    // long enough for the body queue to fill and push back on the input.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && pixels_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= rst_n && receiver_pause();
            end
        end
    end

    function automatic logic [31:0] draw_q16();
        logic signed [31:0] r;
        int                 pick;
        r = $urandom;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return r;
        if (pick == 1)
        begin
            case ($urandom_range(0, 3))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return Q_ZERO;
                default: return Q_NEG;
            endcase
        end
        // Spread the magnitudes so that most trails stay on screen.
        return r >>> $urandom_range(1, 31);
    endfunction

    function automatic body_t random_body();
        body_t b;
        b.pos_x = draw_q16();
        b.pos_y = draw_q16();
        b.pos_z = draw_q16();
        b.vel_x = draw_q16();
        b.vel_y = draw_q16();
        b.vel_z = draw_q16();
        b.acc_x = draw_q16();
        b.acc_y = draw_q16();
        b.acc_z = draw_q16();
        return b;
    endfunction

    function automatic view_set_t view_for_phase(input int phase);
        view_set_t s;
        case (phase)
            1: s = '{18'd65536, 18'd0, 18'd65536, 18'd0, 18'd256, 18'd320, 18'd240, 18'd655};
            2: s = '{NEG_UNIT, NEG_UNIT, NEG_UNIT, NEG_UNIT, 18'd65535, 18'h08000, 18'h07FFF,
                     18'd65535};
            3: s = '{18'd65536, 18'd65536, NEG_UNIT, 18'd65536, 18'd0, 18'h07FFF, 18'h08000,
                     18'd0};
            // Codes past the nominal range, and bits above the width of the 16-bit registers.
            4: s = '{18'h3FFFF, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h3ABCD, 18'h2FFFF,
                     18'h18000, 18'h30001};
            default:
            begin
                s.cos_yaw   = 18'($urandom);
                s.sin_yaw   = 18'($urandom);
                s.cos_pitch = 18'($urandom);
                s.sin_pitch = 18'($urandom);
                s.focal     = 18'($urandom);
                s.center_x  = 18'($urandom);
                s.center_y  = 18'($urandom);
                s.time_step = 18'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic put_reg(input cfg_idx_t idx, input logic [17:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        view_regs[idx] = (idx >= CFG_FOCAL_SCALE) ? (value & 18'h0FFFF) : value;
    endtask

    task automatic load_view(input view_set_t s);
        put_reg(CFG_COS_YAW, s.cos_yaw);
        put_reg(CFG_SIN_YAW, s.sin_yaw);
        put_reg(CFG_COS_PITCH, s.cos_pitch);
        put_reg(CFG_SIN_PITCH, s.sin_pitch);
        put_reg(CFG_FOCAL_SCALE, s.focal);
        put_reg(CFG_CENTER_X, s.center_x);
        put_reg(CFG_CENTER_Y, s.center_y);
        put_reg(CFG_TIME_STEP, s.time_step);
        cfg_write <= 1'b0;
    endtask

    // Leaves valid alone when a pause is not drawn, so back-to-back items keep
    // it high without a second assignment in the same step.
    task automatic offer_body(input body_t b, input pixel_pin_t pin);
        while (sender_pause())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pin_queue.push_back(pin);
        pos_x    <= b.pos_x;
        pos_y    <= b.pos_y;
        pos_z    <= b.pos_z;
        vel_x    <= b.vel_x;
        vel_y    <= b.vel_y;
        vel_z    <= b.vel_z;
        acc_x    <= b.acc_x;
        acc_y    <= b.acc_y;
        acc_z    <= b.acc_z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bodies_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pixels_seen < bodies_sent * TRAIL)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[r])
            offer_body(directed_rows[r].body, directed_rows[r].pin);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                wait_drained();
                load_view(view_for_phase(phase));
            end
            pace = (phase < 3) ? SENDER_SLOW : ((phase < 5) ? RECEIVER_SLOW : NO_IDLE);
            repeat (RANDOM_BODIES)
                offer_body(random_body(), '0);
        end
        wait_drained();
        if (pending_pixels.size() != 0)
        begin
            mismatches += pending_pixels.size();
            $display("%0d expected pixels never arrived", pending_pixels.size());
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
